// File: rtl/core/mhpq_pkg.sv
package mhpq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int KEY_IN_W      = 32;
  localparam int ENTRY_W       = 7;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_REMOVE  = 2'd1,
    K_PEEK    = 2'd2,
    K_REPLACE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [KEY_IN_W-1:0] key_in;
  } req_t;

  typedef struct packed {
    logic [KEY_IN_W-1:0] key_out;
    status_t             status;
    logic [ENTRY_W-1:0]  entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_SEL,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/mhpq_store.sv
module mhpq_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, two ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/mhpq_cmp.sv
module mhpq_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  input  logic                 signed_keys,
  output logic                 above
);

  logic [KEY_WIDTH-1:0] sign_mask;

  // flip the sign bit in signed mode so one unsigned compare serves both orders
  assign sign_mask = KEY_WIDTH'(signed_keys) << (KEY_WIDTH - 1);
  assign above     = (a ^ sign_mask) > (b ^ sign_mask);

endmodule

// File: rtl/core/max_heap_priority_queue_core.sv
// Channel  Dir  Handshake          Beat
// req      in   req_valid/stall    kind, key_in
// rsp      out  rsp_valid/stall    key_out, status, entry_count
// cfg      in   cfg_valid/ready    signed_keys (one bit)
//
// From accept to the result register: a refused insert or an empty heap goes
// straight to the answer, a peek reads the root first, an insert climbs from
// the new leaf toward the root, and a remove/replace reads the root and last
// entry, then sinks the moving key from the root down toward a leaf; each level
// costs a registered heap-store read and a pass through the one shared comparator.
// rst is synchronous: it empties the heap and clears signed_keys; the store
// itself is not cleared, only entries below the count are ever used.
// req_stall stays high until the answer loads; a held rsp beat holds the
// finished answer back, and the request side stalls with it.
module max_heap_priority_queue_core
  import mhpq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int W2    = IDX_W + 2;

  // control state
  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic signed_keys;

  // working registers
  logic [IDX_W-1:0]     idx, idx_next;
  logic [IDX_W-1:0]     par, par_next;
  logic [KEY_WIDTH-1:0] cur, cur_next;
  logic [KEY_WIDTH-1:0] big_key, big_key_next;
  logic [IDX_W-1:0]     big_idx, big_idx_next;
  kind_t                kind, kind_next;
  logic [KEY_IN_W-1:0]  res_key, res_key_next;
  status_t              res_status, res_status_next;
  logic                 load_rsp;

  // store and comparator hookup
  logic                 we;
  logic [IDX_W-1:0]     waddr, ra, rb;
  logic [KEY_WIDTH-1:0] wdata, rd_a, rd_b;
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 above;

  // index arithmetic for the current hole
  logic [W2-1:0]    lft_w, rgt_w;
  logic [CNT_W-1:0] cm1;
  logic [IDX_W-1:0] par_calc;
  logic             has_kids, right_ok;

  assign lft_w    = W2'({idx, 1'b1});
  assign rgt_w    = lft_w + W2'(1);
  assign has_kids = W2'(idx) < W2'(count >> 1);
  assign right_ok = rgt_w < W2'(count);
  assign cm1      = count - CNT_W'(1);
  assign par_calc = (idx - IDX_W'(1)) >> 1;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  mhpq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  mhpq_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .a           (cmp_a),
    .b           (cmp_b),
    .signed_keys (signed_keys),
    .above       (above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      signed_keys <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        signed_keys <= cfg_data;
      end
      // hold a stalled beat, drop it once taken
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    par        <= par_next;
    cur        <= cur_next;
    big_key    <= big_key_next;
    big_idx    <= big_idx_next;
    kind       <= kind_next;
    res_key    <= res_key_next;
    res_status <= res_status_next;
    if (load_rsp) begin
      rsp.key_out     <= res_key;
      rsp.status      <= res_status;
      rsp.entry_count <= ENTRY_W'(count);
    end
  end

  // sequencer: the moving key rides in cur and the hole index in idx, so each
  // level writes one entry instead of swapping two
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    par_next        = par;
    cur_next        = cur;
    big_key_next    = big_key;
    big_idx_next    = big_idx;
    kind_next       = kind;
    res_key_next    = res_key;
    res_status_next = res_status;
    load_rsp        = 1'b0;
    we              = 1'b0;
    waddr           = idx;
    wdata           = cur;
    ra              = '0;
    rb              = '0;
    cmp_a           = cur;
    cmp_b           = rd_a;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          kind_next       = req.kind;
          res_key_next    = '0;
          res_status_next = ST_OK;
          cur_next        = KEY_WIDTH'(req.key_in);
          if (req.kind == K_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              idx_next   = count[IDX_W-1:0];
              count_next = count + CNT_W'(1);
              state_next = S_UP_CHK;
            end
          end else if (count == '0) begin
            res_status_next = ST_EMPTY;
            state_next      = S_DONE;
          end else begin
            // fetch root and last entry together
            ra         = '0;
            rb         = cm1[IDX_W-1:0];
            state_next = S_ROOT;
          end
        end
      end

      S_ROOT: begin
        res_key_next = KEY_IN_W'(rd_a);
        idx_next     = '0;
        unique case (kind)
          K_PEEK: begin
            state_next = S_DONE;
          end
          K_REMOVE: begin
            count_next = cm1;
            cur_next   = rd_b;
            state_next = (cm1 == '0) ? S_DONE : S_DN_CHK;
          end
          K_REPLACE: begin
            state_next = S_DN_CHK;
          end
          K_INSERT: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_UP_CHK: begin
        if (idx == '0) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          ra         = par_calc;
          par_next   = par_calc;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_a = cur;
        cmp_b = rd_a;
        we    = 1'b1;
        if (above) begin
          // pull the parent down into the hole, climb
          wdata      = rd_a;
          idx_next   = par;
          state_next = S_UP_CHK;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DN_CHK: begin
        if (has_kids) begin
          ra         = lft_w[IDX_W-1:0];
          rb         = rgt_w[IDX_W-1:0];
          state_next = S_DN_SEL;
        end else begin
          we         = 1'b1;
          state_next = S_DONE;
        end
      end

      S_DN_SEL: begin
        // larger child; left wins a tie
        cmp_a = rd_b;
        cmp_b = rd_a;
        if (right_ok && above) begin
          big_key_next = rd_b;
          big_idx_next = rgt_w[IDX_W-1:0];
        end else begin
          big_key_next = rd_a;
          big_idx_next = lft_w[IDX_W-1:0];
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_a = big_key;
        cmp_b = cur;
        we    = 1'b1;
        if (above) begin
          wdata      = big_key;
          idx_next   = big_idx;
          state_next = S_DN_CHK;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/mhpq_checker.sv
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken without going busy");

  a_fail_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.key_out == '0)
    else $error("failed request returned a key");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
